@@ hw/rtl/qee_pkg.sv @@
package qee_pkg;

  localparam int NumW    = 22;
  localparam int DbW     = 15;
  localparam int OmegaW  = 16;
  localparam int HpW     = 16;
  localparam int DirW    = 2;
  localparam int CfgIdxW = 4;
  localparam int OutW    = 4;

  localparam logic [CfgIdxW-1:0] CFG_SPEED_NUM = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_DEADBAND  = CfgIdxW'(1);

  localparam logic [NumW-1:0] NUM_RESET      = NumW'(2437112);
  localparam logic [DbW-1:0]  DEADBAND_RESET = DbW'(77);

  localparam logic [DirW-1:0] DIR_STOP = 2'd0;
  localparam logic [DirW-1:0] DIR_FWD  = 2'd1;
  localparam logic [DirW-1:0] DIR_REV  = 2'd2;

  localparam logic [HpW-1:0] HP_MIN = HpW'(1);
  localparam logic [HpW-1:0] HP_MAX = {HpW{1'b1}};

  typedef struct packed {
    logic                     command;
    logic [1:0]               wheel;
    logic signed [OmegaW-1:0] omega;
  } qee_in_t;

  typedef struct packed {
    logic [OutW-1:0] a_levels;
    logic [OutW-1:0] b_levels;
    logic [OutW-1:0] running;
  } qee_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [NumW-1:0]    data;
  } qee_cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic do_tick;
    logic do_stop;
    logic div_start;
    logic do_arm;
    logic load_out;
  } qee_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic wheel_ok;
    logic in_deadband;
    logic div_busy;
    logic out_free;
  } qee_sts_t;

endpackage

@@ hw/rtl/qee_chan_if.sv @@
interface qee_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/qee_div.sv @@
module qee_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [qee_pkg::NumW-1:0]    dividend_i,
  input  logic [qee_pkg::OmegaW-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [qee_pkg::NumW-1:0]    quotient_o
);
  localparam int NW   = qee_pkg::NumW;
  localparam int DW   = qee_pkg::OmegaW;
  localparam int CntW = $clog2(NW + 1);

  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic [DW:0]     rem_sh;
  logic            fits;
  logic [DW-1:0]   rem_d;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[NW-1]};
    fits   = rem_sh >= {1'b0, divisor_i};
    rem_d  = fits ? DW'(rem_sh - {1'b0, divisor_i}) : rem_sh[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;
endmodule

@@ hw/rtl/qee_ctrl.sv @@
module qee_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qee_pkg::qee_sts_t sts_i,
  output qee_pkg::qee_cmd_t cmd_o
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_ARM  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        priority if (sts_i.is_tick) begin
          cmd_o.do_tick = 1'b1;
          state_d       = ST_EMIT;
        end else if (!sts_i.wheel_ok) begin
          state_d = ST_EMIT;
        end else if (sts_i.in_deadband) begin
          cmd_o.do_stop = 1'b1;
          state_d       = ST_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_ARM;
        end
      end
      ST_ARM: begin
        cmd_o.do_arm = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

@@ hw/rtl/qee_dp.sv @@
module qee_dp #(
  parameter int WHEELS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qee_pkg::qee_cmd_t cmd_i,
  output qee_pkg::qee_sts_t sts_o,
  input  qee_pkg::qee_in_t  item_i,
  input  logic              cfg_we_i,
  input  qee_pkg::qee_cfg_t cfg_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qee_pkg::qee_out_t out_o
);
  localparam int HpW  = qee_pkg::HpW;
  localparam int DirW = qee_pkg::DirW;
  localparam int OW   = qee_pkg::OutW;

  logic [qee_pkg::NumW-1:0]   num_q;
  logic [qee_pkg::DbW-1:0]    db_q;
  qee_pkg::qee_in_t           item_q;
  logic                       out_valid_q;
  qee_pkg::qee_out_t          out_q;
  qee_pkg::qee_out_t          snap;

  logic                       neg;
  logic [qee_pkg::OmegaW-1:0] mag;
  logic [DirW-1:0]            new_dir;
  logic [qee_pkg::NumW-1:0]   quot;
  logic                       div_busy;
  logic [HpW-1:0]             hp_new;
  logic [HpW-1:0]             far_off;

  logic [HpW-1:0]    cnt_q  [WHEELS];
  logic [HpW-1:0]    cmpa_q [WHEELS];
  logic [HpW-1:0]    cmpb_q [WHEELS];
  logic [HpW-1:0]    hp_q   [WHEELS];
  logic [DirW-1:0]   dir_q  [WHEELS];
  logic [WHEELS-1:0] lva_q, lvb_q;

  logic [HpW-1:0]    cnt_inc [WHEELS];
  logic [HpW-1:0]    arm_a   [WHEELS];
  logic [HpW-1:0]    arm_b   [WHEELS];
  logic [WHEELS-1:0] run, hit_a, hit_b, sel;

  assign neg     = item_q.omega[qee_pkg::OmegaW-1];
  assign mag     = neg ? (~unsigned'(item_q.omega) + 16'd1) : unsigned'(item_q.omega);
  assign new_dir = neg ? qee_pkg::DIR_REV : qee_pkg::DIR_FWD;

  qee_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_q),
    .divisor_i  (mag),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  always_comb begin
    if (quot > qee_pkg::NumW'(qee_pkg::HP_MAX)) begin
      hp_new = qee_pkg::HP_MAX;
    end else if (quot == '0) begin
      hp_new = qee_pkg::HP_MIN;
    end else begin
      hp_new = quot[HpW-1:0];
    end
    far_off = hp_new + (hp_new >> 1);
  end

  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      sel[w]     = int'(item_q.wheel) == w;
      cnt_inc[w] = cnt_q[w] + HpW'(1);
      run[w]     = dir_q[w] != qee_pkg::DIR_STOP;
      hit_a[w]   = run[w] && (cnt_inc[w] == cmpa_q[w]);
      hit_b[w]   = run[w] && (cnt_inc[w] == cmpb_q[w]);
      arm_a[w]   = cnt_q[w] + ((new_dir == qee_pkg::DIR_FWD) ? hp_new : far_off);
      arm_b[w]   = cnt_q[w] + ((new_dir == qee_pkg::DIR_FWD) ? far_off : hp_new);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < WHEELS; w++) begin
        cnt_q[w]  <= '0;
        cmpa_q[w] <= '0;
        cmpb_q[w] <= '0;
        hp_q[w]   <= '0;
        dir_q[w]  <= qee_pkg::DIR_STOP;
      end
      lva_q <= '0;
      lvb_q <= '0;
    end else begin
      for (int w = 0; w < WHEELS; w++) begin
        if (cmd_i.do_tick) begin
          cnt_q[w] <= cnt_inc[w];
          if (hit_a[w]) begin
            lva_q[w]  <= ~lva_q[w];
            cmpa_q[w] <= cmpa_q[w] + hp_q[w];
          end
          if (hit_b[w]) begin
            lvb_q[w]  <= ~lvb_q[w];
            cmpb_q[w] <= cmpb_q[w] + hp_q[w];
          end
        end
        if (cmd_i.do_stop && sel[w]) begin
          dir_q[w] <= qee_pkg::DIR_STOP;
        end
        if (cmd_i.do_arm && sel[w]) begin
          hp_q[w] <= hp_new;
          if (dir_q[w] != new_dir) begin
            cmpa_q[w] <= arm_a[w];
            cmpb_q[w] <= arm_b[w];
            dir_q[w]  <= new_dir;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= qee_pkg::NUM_RESET;
      db_q  <= qee_pkg::DEADBAND_RESET;
    end else if (cfg_we_i) begin
      if (cfg_i.index == qee_pkg::CFG_SPEED_NUM) begin
        num_q <= cfg_i.data;
      end else if (cfg_i.index == qee_pkg::CFG_DEADBAND) begin
        db_q <= cfg_i.data[qee_pkg::DbW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= item_i;
    end
    if (cmd_i.load_out) begin
      out_q <= snap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  for (genvar g = 0; g < OW; g++) begin : g_snap
    if (g < WHEELS) begin : g_on
      assign snap.a_levels[g] = lva_q[g];
      assign snap.b_levels[g] = lvb_q[g];
      assign snap.running[g]  = run[g];
    end else begin : g_off
      assign snap.a_levels[g] = 1'b0;
      assign snap.b_levels[g] = 1'b0;
      assign snap.running[g]  = 1'b0;
    end
  end

  assign sts_o.is_tick     = !item_q.command;
  assign sts_o.wheel_ok    = int'(item_q.wheel) < WHEELS;
  assign sts_o.in_deadband = mag <= {1'b0, db_q};
  assign sts_o.div_busy    = div_busy;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
endmodule

@@ hw/rtl/quadrature_encoder_emulator_top.sv @@
// Quadrature encoder emulator: A/B square waves 90 degrees apart for up to
// WHEELS wheels, each with its own 16-bit tick counter advanced by tick requests.
// in_i   : one request per item. command 0 advances every wheel by one tick,
//          command 1 sets the Q8.8 signed speed of the wheel given by wheel.
// out_o  : one result per request: A levels, B levels and running mask of
//          wheels 0..3 after the request has been applied.
// cfg_i  : index 0 = speed numerator (22 bit), index 1 = deadband (15 bit).
//          Always ready; write only while no request is in flight.
// Flow   : a tick, a stop or a request for an absent wheel goes from the
//          idle state through EXEC to EMIT; a set-speed request goes through
//          EXEC, DIV, ARM and EMIT, where in DIV the 22-step shift/subtract
//          divider turns the speed into a half period. EMIT waits until
//          the output register is free. in_i is ready only in the idle
//          state, one request at a time.
// Results sit in an output register; a new request is taken while the
// previous result still waits. If the receiver stalls, the next result
// waits in the controller and in_i.ready stays low until the register frees.
// Reset clears counters, compares, levels and directions and loads the
// default numerator and deadband.
module quadrature_encoder_emulator_top #(
  parameter int WHEELS = 4
) (
  input logic      clk_i,
  input logic      rst_ni,
  qee_chan_if.sink   in_i,
  qee_chan_if.sink   cfg_i,
  qee_chan_if.source out_o
);
  qee_pkg::qee_cmd_t cmd;
  qee_pkg::qee_sts_t sts;

  assign cfg_i.ready = 1'b1;

  qee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qee_dp #(
    .WHEELS (WHEELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (in_i.payload),
    .cfg_we_i    (cfg_i.valid),
    .cfg_i       (cfg_i.payload),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (out_o.payload)
  );
endmodule

@@ hw/rtl/qee_chk.sv @@
module qee_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [11:0] out_data_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i)
    else $error("request accepted before previous one finished");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without a request in flight");
endmodule

bind quadrature_encoder_emulator_top qee_chk u_qee_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.payload)
);
